// ===== rtl/tcgr_pkg.sv =====
`timescale 1ns / 1ps

package tcgr_pkg;

  localparam int MAX_COLUMNS  = 128;
  localparam int MAX_ROWS     = 64;
  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_WIDTH  = 8;

  localparam int NUM_CELLS     = MAX_COLUMNS * MAX_ROWS;
  localparam int NUM_FONT_ROWS = 256 * GLYPH_HEIGHT;
  localparam int CELL_AW       = $clog2(NUM_CELLS);
  localparam int FONT_AW       = $clog2(NUM_FONT_ROWS);
  localparam int ROW_W         = $clog2(GLYPH_HEIGHT);
  localparam int COL_W         = $clog2(GLYPH_WIDTH);

  localparam logic [7:0] LVL_OFF = 8'h00;
  localparam logic [7:0] LVL_LO  = 8'h55;
  localparam logic [7:0] LVL_MID = 8'hAA;
  localparam logic [7:0] LVL_HI  = 8'hFF;

  localparam logic [3:0] RESET_BACK = 4'd15;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_READ      = 3'd1,
    OP_MOVE      = 3'd2,
    OP_LOAD_FONT = 3'd3,
    OP_RENDER    = 3'd4
  } opcode_t;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_MOVE_WAIT,
    ST_MOVE_SRC,
    ST_REND_WAIT,
    ST_REND,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [3:0] fore;
    logic [3:0] back;
    logic       dirty;
  } cell_word_t;

  localparam cell_word_t CELL_RESET = '{char_code: 8'd0, fore: 4'd0,
                                        back: RESET_BACK, dirty: 1'b0};

  // Fixed 16-entry palette, packed as {red, green, blue}.
  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = {LVL_OFF, LVL_OFF, LVL_OFF};
      4'd1:    rgb = {LVL_OFF, LVL_OFF, LVL_MID};
      4'd2:    rgb = {LVL_OFF, LVL_MID, LVL_OFF};
      4'd3:    rgb = {LVL_OFF, LVL_MID, LVL_MID};
      4'd4:    rgb = {LVL_MID, LVL_OFF, LVL_OFF};
      4'd5:    rgb = {LVL_MID, LVL_OFF, LVL_MID};
      4'd6:    rgb = {LVL_MID, LVL_LO,  LVL_OFF};
      4'd7:    rgb = {LVL_MID, LVL_MID, LVL_MID};
      4'd8:    rgb = {LVL_LO,  LVL_LO,  LVL_LO};
      4'd9:    rgb = {LVL_LO,  LVL_LO,  LVL_HI};
      4'd10:   rgb = {LVL_LO,  LVL_HI,  LVL_LO};
      4'd11:   rgb = {LVL_LO,  LVL_HI,  LVL_HI};
      4'd12:   rgb = {LVL_HI,  LVL_LO,  LVL_LO};
      4'd13:   rgb = {LVL_HI,  LVL_LO,  LVL_HI};
      4'd14:   rgb = {LVL_HI,  LVL_HI,  LVL_LO};
      default: rgb = {LVL_HI,  LVL_HI,  LVL_HI};
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/tcgr_ram.sv =====
`timescale 1ns / 1ps

module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// ===== rtl/text_cell_glyph_renderer.sv =====
`timescale 1ns / 1ps

// Text cell store with an 8x16 glyph rasterizer. After reset the block sweeps
// the cell memory back to its reset contents, one cell per cycle; busy stays
// high and no command is taken, but configuration writes are. A command is
// taken when start is high and busy is low; the block then works on that one
// word until busy drops again. Write cell and load font row write one word;
// read cell shows its result in the cycle in which busy falls; move copies
// the cell to the destination, then marks the source dirty; render column
// gives, for a dirty cell, 16 pixels, one per cycle, top to bottom, set by
// the single read port of the font memory. Out-of-range cells, clean renders
// and unknown opcodes give nothing. Results are on the result ports for one
// cycle, flagged by result_valid; the receiver must take every one, as there
// is no back-pressure.
module text_cell_glyph_renderer
  import tcgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command word
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [6:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [6:0]  dest_x,
  input  logic [5:0]  dest_y,
  input  logic [7:0]  char_code,
  input  logic [3:0]  fore_colour,
  input  logic [3:0]  back_colour,
  input  logic [3:0]  glyph_row,
  input  logic [7:0]  glyph_bits,
  input  logic [2:0]  glyph_column,
  // result word
  output logic        result_valid,
  output logic [9:0]  pixel_x,
  output logic [9:0]  pixel_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  read_char,
  output logic [3:0]  read_fore,
  output logic [3:0]  read_back,
  output logic        is_read,
  output logic        last,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);
  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(NUM_CELLS - 1);

  state_t state, state_next;

  // configuration registers
  logic [7:0] columns_in_use;
  logic [6:0] rows_in_use;

  // captured command word
  logic [2:0] item_op;
  logic [6:0] item_x, item_dx;
  logic [5:0] item_y, item_dy;
  logic [7:0] item_char, item_bits;
  logic [3:0] item_fore, item_back, item_row;
  logic [2:0] item_col;

  // render context
  logic [7:0]       rend_char;
  logic [3:0]       rend_fore, rend_back;
  logic [ROW_W-1:0] row_cnt;
  logic             fr_valid;
  logic [ROW_W-1:0] fr_row;

  logic [CELL_AW-1:0] clr_addr;
  cell_word_t         move_word;

  // memory ports
  logic               cell_we, cell_re;
  logic [CELL_AW-1:0] cell_waddr, cell_raddr;
  cell_word_t         cell_wdata, cell_q;
  logic               font_we, font_re;
  logic [FONT_AW-1:0] font_waddr, font_raddr;
  logic [7:0]         font_q;

  logic               accept, src_ok, dst_ok;
  logic [CELL_AW-1:0] src_addr, dst_addr;
  logic               pix_on;
  logic [23:0]        pix_rgb;

  tcgr_ram #(.WIDTH($bits(cell_word_t)), .DEPTH(NUM_CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .q     (cell_q)
  );

  tcgr_ram #(.WIDTH(8), .DEPTH(NUM_FONT_ROWS)) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (item_bits),
    .re    (font_re),
    .raddr (font_raddr),
    .q     (font_q)
  );

  assign accept = start && !busy;

  // Range checks: both the programmed screen size and the store size apply.
  assign src_ok = ({1'b0, item_x} < columns_in_use) && (32'(item_x) < MAX_COLUMNS) &&
                  ({1'b0, item_y} < rows_in_use) && (32'(item_y) < MAX_ROWS);
  assign dst_ok = ({1'b0, item_dx} < columns_in_use) && (32'(item_dx) < MAX_COLUMNS) &&
                  ({1'b0, item_dy} < rows_in_use) && (32'(item_dy) < MAX_ROWS);

  // Row stride is MAX_COLUMNS, so the address is just row over column.
  assign src_addr = CELL_AW'(32'(item_y) * MAX_COLUMNS + 32'(item_x));
  assign dst_addr = CELL_AW'(32'(item_dy) * MAX_COLUMNS + 32'(item_dx));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_CELL) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        unique case (item_op)
          OP_READ:   if (src_ok) state_next = ST_READ_WAIT;
          OP_MOVE:   if (src_ok && dst_ok) state_next = ST_MOVE_WAIT;
          OP_RENDER: if (src_ok) state_next = ST_REND_WAIT;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_READ_WAIT: state_next = ST_IDLE;
      ST_MOVE_WAIT: state_next = ST_MOVE_SRC;
      ST_MOVE_SRC:  state_next = ST_IDLE;
      ST_REND_WAIT: state_next = cell_q.dirty ? ST_REND : ST_IDLE;
      ST_REND: begin
        if (row_cnt == LAST_ROW) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    busy       = (state != ST_IDLE);
    cell_we    = 1'b0;
    cell_waddr = src_addr;
    cell_wdata = CELL_RESET;
    cell_re    = 1'b0;
    cell_raddr = src_addr;
    font_we    = 1'b0;
    font_waddr = {item_char, item_row};
    font_re    = 1'b0;
    font_raddr = {rend_char, row_cnt};
    unique case (state) inside
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr;
      end
      ST_EXEC: begin
        unique case (item_op) inside
          OP_WRITE: begin
            cell_we    = src_ok;
            cell_wdata = '{char_code: item_char, fore: item_fore, back: item_back,
                           dirty: 1'b1};
          end
          OP_LOAD_FONT: font_we = 1'b1;
          OP_READ, OP_RENDER: cell_re = src_ok;
          OP_MOVE:  cell_re = src_ok && dst_ok;
          default: cell_re = 1'b0;
        endcase
      end
      ST_MOVE_WAIT: begin
        // copy to the destination first, then mark the source
        cell_we       = 1'b1;
        cell_waddr    = dst_addr;
        cell_wdata    = cell_q;
        cell_wdata.dirty = 1'b1;
      end
      ST_MOVE_SRC: begin
        cell_we    = 1'b1;
        cell_wdata = move_word;
      end
      ST_REND_WAIT: begin
        // the rightmost column render cleans the cell
        cell_we          = cell_q.dirty && (item_col == LAST_COL);
        cell_wdata       = cell_q;
        cell_wdata.dirty = 1'b0;
      end
      ST_REND: font_re = 1'b1;
      ST_IDLE, ST_READ_WAIT, ST_DRAIN: font_re = 1'b0;
      default: font_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      fr_valid <= 1'b0;
      result_valid <= 1'b0;
      columns_in_use <= 8'd80;
      rows_in_use    <= 7'd25;
    end else begin
      state    <= state_next;
      fr_valid <= (state == ST_REND);
      result_valid <= (state == ST_READ_WAIT) || fr_valid;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_COLUMNS: columns_in_use <= cfg_data;
          REG_ROWS:    rows_in_use    <= cfg_data[6:0];
          default:     rows_in_use    <= rows_in_use;
        endcase
      end
    end
  end

  // payload: capture the command word, hold render context
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op   <= opcode;
      item_x    <= cell_x;
      item_y    <= cell_y;
      item_dx   <= dest_x;
      item_dy   <= dest_y;
      item_char <= char_code;
      item_fore <= fore_colour;
      item_back <= back_colour;
      item_row  <= glyph_row;
      item_bits <= glyph_bits;
      item_col  <= glyph_column;
    end
    if (state == ST_MOVE_WAIT) begin
      move_word       <= cell_q;
      move_word.dirty <= 1'b1;
    end
    if (state == ST_REND_WAIT) begin
      rend_char <= cell_q.char_code;
      rend_fore <= cell_q.fore;
      rend_back <= cell_q.back;
      row_cnt   <= '0;
    end else if (state == ST_REND) begin
      row_cnt <= row_cnt + 1'b1;
    end
    fr_row <= row_cnt;
  end

  // Bit 7 of a font row is the leftmost pixel.
  assign pix_on  = font_q[LAST_COL - item_col];
  assign pix_rgb = palette_rgb(pix_on ? rend_fore : rend_back);

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_READ_WAIT) begin
      pixel_x   <= '0;
      pixel_y   <= '0;
      red       <= '0;
      green     <= '0;
      blue      <= '0;
      read_char <= cell_q.char_code;
      read_fore <= cell_q.fore;
      read_back <= cell_q.back;
      is_read   <= 1'b1;
      last      <= 1'b1;
    end else if (fr_valid) begin
      pixel_x   <= {item_x, item_col};
      pixel_y   <= {item_y[5:0], fr_row};
      red       <= pix_rgb[23:16];
      green     <= pix_rgb[15:8];
      blue      <= pix_rgb[7:0];
      read_char <= '0;
      read_fore <= '0;
      read_back <= '0;
      is_read   <= 1'b0;
      last      <= (fr_row == LAST_ROW);
    end
  end

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !result_valid)
    else $error("result word during the clearing sweep");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a command word");

  a_read_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_read) |-> last)
    else $error("read result not flagged last");

  a_last_pixel_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_read && last) |-> (pixel_y[ROW_W-1:0] == LAST_ROW))
    else $error("last pixel is not the bottom glyph row");
`endif

endmodule
